// ===== hw/rtl/multi_class_priority_deque_top_defines.svh =====
// Assertion macros for the multi-class priority deque checker.
// No dependencies; expects clk and arst_n in the scope of each use.
`ifndef MULTI_CLASS_PRIORITY_DEQUE_TOP_DEFINES_SVH
`define MULTI_CLASS_PRIORITY_DEQUE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MCPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define MCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mcpd_pkg.sv =====
// Shared types and constants for the multi-class priority deque.
// No dependencies.
`timescale 1ns / 1ps

package mcpd_pkg;

	localparam int NUM_QUEUES  = 32;
	localparam int QUEUE_DEPTH = 8;
	localparam int ID_WIDTH    = 16;

	localparam int QSEL_W  = 5;
	localparam int QIDX_W  = $clog2(NUM_QUEUES);
	localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = SLOT_W + 1;
	localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int ENTRY_W = ID_WIDTH + 1;

	typedef logic [QSEL_W-1:0]   qsel_t;
	typedef logic [QIDX_W-1:0]   qidx_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [ID_WIDTH-1:0] id_t;
	typedef logic [ENTRY_W-1:0]  entry_t;

	typedef enum logic {
		KIND_ADD  = 1'b0,
		KIND_TAKE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		RES_ADDED  = 2'd0,
		RES_FULL   = 2'd1,
		RES_SERVED = 2'd2,
		RES_EMPTY  = 2'd3
	} result_t;

	typedef struct packed {
		kind_t kind;
		qsel_t queue_select;
		id_t   entry_id;
		logic  urgent;
	} item_t;

	// outcome of one item, from the pointer table to the datapath
	typedef struct packed {
		result_t code;
		cnt_t    count;
		logic    we;
		logic    re;
		addr_t   addr;
	} dec_t;

endpackage

// ===== hw/rtl/mcpd_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/mcpd_ctrl.sv =====
// Per-queue head pointer and fill count table plus the add/take decision.
// Depends on mcpd_pkg.
`timescale 1ns / 1ps

module mcpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  mcpd_pkg::item_t item,
	input  logic           go,
	output mcpd_pkg::dec_t dec
);
	import mcpd_pkg::*;

	slot_t head_q  [NUM_QUEUES];
	cnt_t  count_q [NUM_QUEUES];

	qidx_t qidx;
	logic  in_range;
	slot_t head;
	cnt_t  cnt;
	slot_t head_dec;
	slot_t head_inc;
	logic [SUM_W-1:0] tail_sum;
	slot_t tail;
	slot_t slot;
	slot_t new_head;
	cnt_t  new_cnt;
	logic  upd;

	assign qidx     = QIDX_W'(item.queue_select);
	assign in_range = (32'(item.queue_select) < NUM_QUEUES);
	assign head     = head_q[qidx];
	assign cnt      = count_q[qidx];

	// circular wrap without a divider
	assign head_dec = (head == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : head - 1'b1;
	assign head_inc = (head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
	assign tail_sum = SUM_W'(head) + SUM_W'(cnt);
	assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);

	always_comb begin
		dec.code  = RES_FULL;
		dec.count = '0;
		dec.we    = 1'b0;
		dec.re    = 1'b0;
		slot      = head;
		new_head  = head;
		new_cnt   = cnt;
		upd       = 1'b0;
		unique case (item.kind)
			KIND_ADD: begin
				dec.code = RES_FULL;
				if (in_range) begin
					dec.count = cnt;
					if (cnt < CNT_W'(QUEUE_DEPTH)) begin
						dec.code  = RES_ADDED;
						dec.we    = 1'b1;
						slot      = item.urgent ? head_dec : tail;
						new_head  = item.urgent ? head_dec : head;
						new_cnt   = cnt + 1'b1;
						dec.count = new_cnt;
						upd       = 1'b1;
					end
				end
			end
			KIND_TAKE: begin
				dec.code = RES_EMPTY;
				if (in_range && cnt != '0) begin
					dec.code  = RES_SERVED;
					dec.re    = 1'b1;
					slot      = head;
					new_head  = head_inc;
					new_cnt   = cnt - 1'b1;
					dec.count = new_cnt;
					upd       = 1'b1;
				end
			end
			default: begin
				dec.code = RES_FULL;
			end
		endcase
		dec.addr = ADDR_W'(qidx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (go && upd) begin
			head_q[qidx]  <= new_head;
			count_q[qidx] <= new_cnt;
		end
	end

endmodule

// ===== hw/rtl/multi_class_priority_deque_top.sv =====
// Multi-class priority deque: 32 bounded queues of 8 entries with head push.
// Items pass an input and a result register; one item per cycle unless stalled.
// Each added or served entry costs one entry RAM access and one pointer table update.
// Reset clears head pointers, fill counts and pipeline valids at once; the entry RAM
// is not cleared and needs no clearing pass.
// Depends on mcpd_pkg, mcpd_ctrl, mcpd_ram.
`timescale 1ns / 1ps

module multi_class_priority_deque_top (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                kind,
	input  mcpd_pkg::qsel_t     queue_select,
	input  mcpd_pkg::id_t       entry_id,
	input  logic                urgent,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          result_code,
	output mcpd_pkg::id_t       served_id,
	output logic                served_urgent,
	output logic [3:0]          queue_count
);
	import mcpd_pkg::*;

	// stage 1: registered input item
	logic  valid_s1;
	item_t item_s1;

	// stage 2: result register (entry data sits in the RAM read register)
	logic    valid_s2;
	result_t code_s2;
	cnt_t    count_s2;
	logic    serve_s2;

	dec_t   dec;
	logic   s2_free;
	logic   go;
	entry_t rdata;

	// s2 can take a new result when empty or when its transfer completes
	assign s2_free    = !valid_s2 || !result_stall;
	// s1 hands its item over; state and RAM are touched only on this edge
	assign go         = valid_s1 && s2_free;
	assign item_stall = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1.kind         <= kind_t'(kind);
			item_s1.queue_select <= queue_select;
			item_s1.entry_id     <= entry_id;
			item_s1.urgent       <= urgent;
		end
	end

	mcpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.go     (go),
		.dec    (dec)
	);

	// add writes {urgent, id}; take reads the head slot into the read register,
	// which then holds while the result waits on a stall
	mcpd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (go && (dec.we || dec.re)),
		.we    (dec.we),
		.addr  (dec.addr),
		.wdata ({item_s1.urgent, item_s1.entry_id}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			code_s2  <= dec.code;
			count_s2 <= dec.count;
			serve_s2 <= dec.re;
		end
	end

	// id and flag are zero unless an entry was served
	assign result_valid  = valid_s2;
	assign result_code   = code_s2;
	assign served_id     = serve_s2 ? rdata[ID_WIDTH-1:0] : '0;
	assign served_urgent = serve_s2 & rdata[ID_WIDTH];
	assign queue_count   = 4'(count_s2);

endmodule

// ===== hw/rtl/mcpd_checker.sv =====
// Port-level checker for the multi-class priority deque, bound to the top.
// Depends on mcpd_pkg and multi_class_priority_deque_top_defines.svh.
`timescale 1ns / 1ps
`include "multi_class_priority_deque_top_defines.svh"

module mcpd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_stall,
	input logic            kind,
	input mcpd_pkg::qsel_t queue_select,
	input mcpd_pkg::id_t   entry_id,
	input logic            urgent,
	input logic            result_valid,
	input logic            result_stall,
	input logic [1:0]      result_code,
	input mcpd_pkg::id_t   served_id,
	input logic            served_urgent,
	input logic [3:0]      queue_count
);
	import mcpd_pkg::*;

	`MCPD_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(result_code) && $stable(served_id) &&
		$stable(served_urgent) && $stable(queue_count),
		"stalled result changed")

	`MCPD_ASSERT_NOW(a_id_only_served,
		result_valid && result_code != RES_SERVED,
		served_id == '0 && served_urgent == 1'b0,
		"entry data shown without a served entry")

	`MCPD_ASSERT_NOW(a_empty_count, result_valid && result_code == RES_EMPTY,
		queue_count == 4'd0, "empty queue reported nonzero count")

	`MCPD_ASSERT_NOW(a_added_count, result_valid && result_code == RES_ADDED,
		queue_count != 4'd0 && 32'(queue_count) <= QUEUE_DEPTH,
		"count after add out of range")

endmodule

bind multi_class_priority_deque_top mcpd_checker u_mcpd_checker (.*);

// ===== bench/tb_multi_class_priority_deque_top.sv =====
// Self-checking testbench for multi_class_priority_deque_top.
// Depends on mcpd_pkg and the RTL of the deque; it has its own model of the queues.
`timescale 1ns / 1ps

module tb_multi_class_priority_deque_top;
	import mcpd_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT = 4000;
	// pipeline depth is two registers; a few extra cycles catch stray results
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_ITEMS   = 375;

	// one result transfer as the block should produce it
	typedef struct packed {
		result_t    code;
		id_t        id;
		logic       urg;
		logic [3:0] count;
	} outcome_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       item_valid    = 1'b0;
	logic       item_stall;
	logic       kind          = 1'b0;
	qsel_t      queue_select  = '0;
	id_t        entry_id      = '0;
	logic       urgent        = 1'b0;
	logic       result_valid;
	logic       result_stall  = 1'b0;
	logic [1:0] result_code;
	id_t        served_id;
	logic       served_urgent;
	logic [3:0] queue_count;

	multi_class_priority_deque_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.kind          (kind),
		.queue_select  (queue_select),
		.entry_id      (entry_id),
		.urgent        (urgent),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_code   (result_code),
		.served_id     (served_id),
		.served_urgent (served_urgent),
		.queue_count   (queue_count)
	);

	// shadow copy of the queue state
	int   head_ptr   [NUM_QUEUES];
	int   fill_level [NUM_QUEUES];
	id_t  slot_id    [NUM_QUEUES][QUEUE_DEPTH];
	logic slot_urg   [NUM_QUEUES][QUEUE_DEPTH];

	outcome_t pending_results[$];
	int       mismatch_count     = 0;
	int       sender_idle_pct    = 0;
	int       receiver_stall_pct = 0;
	int       quiet_cycles       = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one item to the shadow state and return the result it must give.
	function automatic outcome_t deque_predict(kind_t k, qsel_t q, id_t id, logic u);
		outcome_t o;
		int       qi;
		int       h;
		int       n;
		int       s;
		o.code  = RES_ADDED;
		o.id    = '0;
		o.urg   = 1'b0;
		o.count = '0;
		qi = int'(q);
		// classes past the table touch nothing
		if (qi >= NUM_QUEUES) begin
			o.code = (k == KIND_TAKE) ? RES_EMPTY : RES_FULL;
			return o;
		end
		h = head_ptr[qi];
		n = fill_level[qi];
		if (k == KIND_ADD) begin
			if (n >= QUEUE_DEPTH) begin
				o.code  = RES_FULL;
				o.count = 4'(n);
				return o;
			end
			if (u) begin
				// urgent entries go in front of the head
				h = (h + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
				s = h;
				head_ptr[qi] = h;
			end else begin
				s = (h + n) % QUEUE_DEPTH;
			end
			slot_id[qi][s]  = id;
			slot_urg[qi][s] = u;
			fill_level[qi]  = n + 1;
			o.count = 4'(n + 1);
			return o;
		end
		if (n == 0) begin
			o.code = RES_EMPTY;
			return o;
		end
		o.code  = RES_SERVED;
		o.id    = slot_id[qi][h];
		o.urg   = slot_urg[qi][h];
		o.count = 4'(n - 1);
		head_ptr[qi]   = (h + 1) % QUEUE_DEPTH;
		fill_level[qi] = n - 1;
		return o;
	endfunction

	// Present one item, hold it until the block takes it, then log the
	// result it must give. Returns at the edge of the transfer.
	task automatic send_item(kind_t k, qsel_t q, id_t id, logic u);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		kind         <= k;
		queue_select <= q;
		entry_id     <= id;
		urgent       <= u;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_results.push_back(deque_predict(k, q, id, u));
	endtask

	// Takes from empty queues at both ends of the class range, ids at
	// both extremes, and takes whose id and flag fields are junk.
	task automatic test_empty_and_extremes();
		send_item(KIND_TAKE, qsel_t'(0), 16'h0000, 1'b0);
		send_item(KIND_TAKE, qsel_t'(NUM_QUEUES - 1), 16'hFFFF, 1'b1);
		send_item(KIND_ADD, qsel_t'(NUM_QUEUES - 1), 16'hFFFF, 1'b0);
		send_item(KIND_ADD, qsel_t'(NUM_QUEUES - 1), 16'h0000, 1'b1);
		send_item(KIND_TAKE, qsel_t'(NUM_QUEUES - 1), 16'h5A5A, 1'b0);
		send_item(KIND_TAKE, qsel_t'(NUM_QUEUES - 1), 16'hA5A5, 1'b1);
		send_item(KIND_TAKE, qsel_t'(NUM_QUEUES - 1), 16'hFFFF, 1'b1);
	endtask

	// Newest urgent entry must come out first, ahead of regular ones.
	task automatic test_urgent_order();
		send_item(KIND_ADD, qsel_t'(3), 16'h0001, 1'b0);
		send_item(KIND_ADD, qsel_t'(3), 16'h0002, 1'b1);
		send_item(KIND_ADD, qsel_t'(3), 16'h0003, 1'b1);
		send_item(KIND_TAKE, qsel_t'(3), 16'h0000, 1'b0);
		send_item(KIND_TAKE, qsel_t'(3), 16'h0000, 1'b0);
		send_item(KIND_TAKE, qsel_t'(3), 16'h0000, 1'b0);
	endtask

	// Fill one class to the brim, then an urgent add must bounce.
	task automatic test_full_queue();
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_item(KIND_ADD, qsel_t'(17), id_t'(16'h1000 + i), logic'(i % 2));
		send_item(KIND_ADD, qsel_t'(17), 16'hBEEF, 1'b1);
		send_item(KIND_TAKE, qsel_t'(17), 16'h0000, 1'b0);
		send_item(KIND_TAKE, qsel_t'(17), 16'h0000, 1'b0);
	endtask

	// Mixed traffic concentrated on a few hot classes so queues run full
	// and empty often; the add/take balance shifts every burst.
	task automatic test_random_traffic(int n_items, int send_pct, int stall_pct);
		qsel_t hot_q[3];
		int    add_pct;
		qsel_t q;
		kind_t k;
		sender_idle_pct    = send_pct;
		receiver_stall_pct = stall_pct;
		add_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				foreach (hot_q[j])
					hot_q[j] = qsel_t'($urandom_range(NUM_QUEUES - 1));
				case ($urandom_range(2))
					0: begin
						add_pct = 80;
					end
					1: begin
						add_pct = 50;
					end
					default: begin
						add_pct = 20;
					end
				endcase
			end
			if ($urandom_range(99) < 70)
				q = hot_q[$urandom_range(2)];
			else
				q = qsel_t'($urandom_range(NUM_QUEUES - 1));
			k = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_TAKE;
			send_item(k, q, id_t'($urandom), logic'($urandom_range(1)));
		end
	endtask

	// Receiver side: random stall per cycle at the current rate.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Result checker: every result transfer against the oldest expectation.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: code %0d id %0h",
					result_code, served_id);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_code !== want.code) begin
					$error("result_code: expected %0d, got %0d", want.code, result_code);
					mismatch_count++;
				end
				if (served_id !== want.id) begin
					$error("served_id: expected %0h, got %0h", want.id, served_id);
					mismatch_count++;
				end
				if (served_urgent !== want.urg) begin
					$error("served_urgent: expected %0b, got %0b", want.urg, served_urgent);
					mismatch_count++;
				end
				if (queue_count !== want.count) begin
					$error("queue_count: expected %0d, got %0d", want.count, queue_count);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		// shadow state matches the block after reset
		foreach (head_ptr[i]) begin
			head_ptr[i]   = 0;
			fill_level[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_urgent_order();
		test_full_queue();

		// idle phases: none, sender gaps, receiver stalls, both light
		test_random_traffic(RANDOM_ITEMS, 0, 0);
		test_random_traffic(RANDOM_ITEMS, 53, 0);
		test_random_traffic(RANDOM_ITEMS, 0, 53);
		test_random_traffic(RANDOM_ITEMS, 10, 10);

		item_valid <= 1'b0;
		receiver_stall_pct = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mcpd_pkg.sv
hw/rtl/mcpd_ram.sv
hw/rtl/mcpd_ctrl.sv
hw/rtl/multi_class_priority_deque_top.sv
hw/rtl/mcpd_checker.sv
bench/tb_multi_class_priority_deque_top.sv
